// ===== hdl/ilst_pkg.sv =====
// Shared types and constants for the indexed list store.
`timescale 1ns / 1ps

package ilst_pkg;

	localparam int CAPACITY = 16;
	localparam int VAL_W    = 32;
	localparam int FUNC_W   = 3;
	localparam int POS_W    = 5;
	localparam int LEN_W    = 5;
	localparam int ST_W     = 2;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// Width used for comparing positions against cell indexes and the count.
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 40;

	typedef enum logic [FUNC_W-1:0] {
		OP_READ   = 3'd0,
		OP_FRONT  = 3'd1,
		OP_BACK   = 3'd2,
		OP_BEFORE = 3'd3,
		OP_DELETE = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [CMP_W-1:0] pos;
	} cell_cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic [ST_W-1:0]  status;
		logic [LEN_W-1:0] length;
	} result_t;

endpackage

// ===== hdl/ilst_cell.sv =====
// One storage cell of the list row; shifts with its neighbors on insert and delete.
`timescale 1ns / 1ps

module ilst_cell (
	input  logic                      clk,
	input  logic [ilst_pkg::CMP_W-1:0] idx,
	input  ilst_pkg::cell_cmd_t       cmd,
	input  logic [ilst_pkg::VAL_W-1:0] new_value,
	input  logic [ilst_pkg::VAL_W-1:0] left_value,
	input  logic [ilst_pkg::VAL_W-1:0] right_value,
	output logic [ilst_pkg::VAL_W-1:0] cell_value,
	output logic [ilst_pkg::VAL_W-1:0] read_tap
);
	import ilst_pkg::*;

	logic [VAL_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (idx == cmd.pos) begin
				entry_q <= new_value;
			end else if (idx > cmd.pos) begin
				entry_q <= left_value;
			end
		end else if (cmd.del && (idx >= cmd.pos)) begin
			entry_q <= right_value;
		end
	end

	assign cell_value = entry_q;
	// Only the addressed cell drives the shared read bus.
	assign read_tap   = (idx == cmd.pos) ? entry_q : '0;

endmodule

// ===== hdl/ilst_ctrl.sv =====
// Operation decode, range and full checks, and the list length register.
`timescale 1ns / 1ps

module ilst_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [ilst_pkg::FUNC_W-1:0] func,
	input  logic [ilst_pkg::POS_W-1:0]  position,
	input  logic [ilst_pkg::VAL_W-1:0]  read_bus,
	output ilst_pkg::cell_cmd_t         cmd,
	output ilst_pkg::result_t           result,
	output logic [ilst_pkg::CNT_W-1:0]  count
);
	import ilst_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] ins_pos;
	logic             full;
	logic             do_ins;
	logic             do_del;
	logic             is_ins;
	status_t          st;
	logic [VAL_W-1:0] rd;

	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(count_q);
	assign full  = (count_q >= CNT_W'(CAPACITY));

	always_comb begin
		ins_pos = pos_x;
		is_ins  = 1'b0;
		do_del  = 1'b0;
		st      = ST_DONE;
		rd      = '0;
		case (op_t'(func))
			OP_READ: begin
				if (pos_x < cnt_x) begin
					rd = read_bus;
				end else begin
					rd = '1;
					st = ST_RANGE;
				end
			end
			OP_FRONT: begin
				ins_pos = '0;
				is_ins  = 1'b1;
			end
			OP_BACK: begin
				ins_pos = cnt_x;
				is_ins  = 1'b1;
			end
			OP_BEFORE: begin
				is_ins = 1'b1;
			end
			OP_DELETE: begin
				if (pos_x < cnt_x) begin
					do_del = 1'b1;
				end else begin
					st = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
		do_ins = 1'b0;
		if (is_ins) begin
			// The position check wins over the full check.
			if (ins_pos > cnt_x) begin
				st = ST_RANGE;
			end else if (full) begin
				st = ST_FULL;
			end else begin
				do_ins = 1'b1;
			end
		end
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = CNT_W'(count_q + 1'b1);
		end else if (do_del) begin
			count_nxt = CNT_W'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	assign cmd.ins           = accept & do_ins;
	assign cmd.del           = accept & do_del;
	assign cmd.pos           = ins_pos;
	assign result.read_value = rd;
	assign result.status     = st;
	assign result.length     = LEN_W'(count_nxt);
	assign count             = count_q;

endmodule

// ===== hdl/indexed_list_store_unit.sv =====
// Top level of the indexed list store: stream ports, cell row and result register.
//
//  channel | dir | tdata fields, lowest bit first
//  s_*     | in  | func[2:0], position[7:3], value[39:8]
//  m_*     | out | read_value[31:0], status[33:32], length[38:34], zero fill
//
// One word is taken per cycle; its result appears in the output register on the
// next cycle. Every cell shifts in the same cycle. Reset clears the list length
// and the output valid; cell contents are left as they are. When a result waits
// with m_tready low, s_tready drops until that result is taken.
`timescale 1ns / 1ps

module indexed_list_store_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ilst_pkg::IN_W-1:0]    s_tdata,  // func, position, value
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ilst_pkg::OUT_W-1:0]   m_tdata   // read_value, status, length, zero fill
);
	import ilst_pkg::*;

	logic                accept;
	logic [FUNC_W-1:0]   func;
	logic [POS_W-1:0]    position;
	logic [VAL_W-1:0]    value;
	cell_cmd_t           cmd;
	result_t             result;
	logic [CNT_W-1:0]    count;
	logic [VAL_W-1:0]    cell_value [CAPACITY];
	logic [VAL_W-1:0]    read_tap   [CAPACITY];
	logic [VAL_W-1:0]    read_bus;
	logic                out_valid_q;
	result_t             out_q;

	assign func     = s_tdata[2:0];
	assign position = s_tdata[7:3];
	assign value    = s_tdata[39:8];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	ilst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (func),
		.position (position),
		.read_bus (read_bus),
		.cmd      (cmd),
		.result   (result),
		.count    (count)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left_v;
		logic [VAL_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = cell_value[i];
		end else begin : g_mid_l
			assign left_v = cell_value[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_value[i];
		end else begin : g_mid_r
			assign right_v = cell_value[i+1];
		end
		ilst_cell u_cell (
			.clk         (clk),
			.idx         (CMP_W'(i)),
			.cmd         (cmd),
			.new_value   (value),
			.left_value  (left_v),
			.right_value (right_v),
			.cell_value  (cell_value[i]),
			.read_tap    (read_tap[i])
		);
	end

	always_comb begin
		read_bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			read_bus = read_bus | read_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	// The packed struct keeps read_value in its top bits, so the word is built by field.
	assign m_tdata  = OUT_W'({out_q.length, out_q.status, out_q.read_value});

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(CAPACITY))
		else $error("list length exceeds capacity");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[33:32] == ST_FULL) |-> (m_tdata[38:34] == LEN_W'(CAPACITY)))
		else $error("full status with list not at capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count))
		else $error("length changed without an accepted word");

	a_out_follow: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted word produced no result");

endmodule
